@@ design/asp_pkg.sv @@
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and constants for the aging slot pool: command codes, register
// addresses and the request bundle of the iterative divider.
// ----------------------------------------------------------------------------
package asp_pkg;

    // Input item command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SPAWN = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_QUERY = 2'd3
    } asp_cmd_t;

    // Register index, taken from paddr[3:2]
    localparam logic [1:0] REG_MAX_SLOTS  = 2'd0;
    localparam logic [1:0] REG_HOLD_TICKS = 2'd1;
    localparam logic [1:0] REG_FADE_TICKS = 2'd2;

    // Register reset values
    localparam logic [6:0]  MAX_SLOTS_RST  = 7'd64;
    localparam logic [15:0] HOLD_TICKS_RST = 16'd10000;
    localparam logic [15:0] FADE_TICKS_RST = 16'd2000;

    // Full opacity in Q0.16
    localparam logic [15:0] OPACITY_FULL = 16'hFFFF;

    // Divider request: num / den, quotient known to fit 16 bits
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [15:0] den;
    } asp_div_req_t;

endpackage

@@ design/aging_slot_pool_evict_oldest.sv @@
// ----------------------------------------------------------------------------
// aging_slot_pool_evict_oldest
// Pool of aging slots with spawn, tick, clear and opacity query. Slot ages and
// copied hold/fade lengths sit in RAM and are walked by one scan sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_tvalid/s_tready  | tuser: command; tdata: delta, query_slot
//  m_       | out       | m_tvalid/m_tready  | tdata: granted, slot, evicted,
//           |           |                    |        opacity, active_count
//  apb      | in        | psel/penable       | max_slots, hold_ticks, fade_ticks
//
//  Tick: one slot per cycle through the age RAM port.
//  Spawn: scan the slots in use for a free or oldest slot, then write.
//  Query: read the slot, then a pass through the bit-serial divider while
//  fading. A finished item waits in the output register while the next one
//  is taken. Reset clears all slots at once.
// ----------------------------------------------------------------------------
module aging_slot_pool_evict_oldest #(
    parameter int SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] delta, [21:16] query_slot, [23:22] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] granted, [6:1] slot, [7] evicted,
                                   // [23:8] opacity, [30:24] active_count, [31] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import asp_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [10:0]   SLOTS_W = 11'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_SPN_SCAN,
        S_SPN_WR,
        S_QRD,
        S_QCALC,
        S_QDIV,
        S_DONE
    } state_t;

    state_t            state_reg,      state_next;
    logic [CW-1:0]     idx_reg,        idx_next;
    logic              pv_reg,         pv_next;
    logic [IW-1:0]     pidx_reg,       pidx_next;
    logic [SLOTS-1:0]  active_reg,     active_next;
    logic [CW-1:0]     cnt_reg,        cnt_next;
    logic [CW-1:0]     used_reg,       used_next;
    logic [15:0]       delta_reg,      delta_next;
    logic [5:0]        q_reg,          q_next;
    logic              free_found_reg, free_found_next;
    logic [IW-1:0]     free_idx_reg,   free_idx_next;
    logic              old_found_reg,  old_found_next;
    logic [IW-1:0]     old_idx_reg,    old_idx_next;
    logic [15:0]       best_reg,       best_next;
    logic              granted_reg,    granted_next;
    logic [5:0]        slot_reg,       slot_next;
    logic              evicted_reg,    evicted_next;
    logic [15:0]       opacity_reg,    opacity_next;
    logic              m_tvalid_reg,   m_tvalid_next;
    logic [31:0]       m_tdata_reg,    m_tdata_next;
    logic [6:0]        max_reg,        max_next;
    logic [15:0]       hold_reg,       hold_next;
    logic [15:0]       fade_reg,       fade_next;

    // RAM ports
    logic              age_we;
    logic [15:0]       age_wdata;
    logic              hf_we;
    logic [IW-1:0]     waddr;
    logic [IW-1:0]     raddr;
    logic [15:0]       age_rd;
    logic [31:0]       hf_rd;

    // Divider
    asp_div_req_t      div_req;
    logic              div_done;
    logic [15:0]       div_quo;

    // Scratch
    asp_cmd_t          in_cmd;
    logic [CW-1:0]     scan_end;
    logic              issue;
    logic [16:0]       age_sum;
    logic [15:0]       age_sat;
    logic [16:0]       life;
    logic [MW-1:0]     limit;
    logic              open_ok;
    logic [IW-1:0]     pick;
    logic [IW-1:0]     qidx;
    logic              q_inrange;
    logic [15:0]       over;
    logic [15:0]       dcl;
    logic [15:0]       remain;
    logic              cfg_wr;

    assign in_cmd  = asp_cmd_t'(s_tuser);
    assign qidx    = IW'(q_reg);
    assign cfg_wr  = psel && penable && pwrite;
    assign raddr   = (state_reg == S_QRD) ? qidx : idx_reg[IW-1:0];

    // Age per slot
    asp_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (waddr),
        .wdata (age_wdata),
        .raddr (raddr),
        .rdata (age_rd)
    );

    // Copied fade (upper) and hold (lower) per slot
    asp_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hf_ram (
        .clk   (clk),
        .we    (hf_we),
        .waddr (waddr),
        .wdata ({fade_reg, hold_reg}),
        .raddr (raddr),
        .rdata (hf_rd)
    );

    asp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Register read
    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_SLOTS:  prdata = {25'd0, max_reg};
            REG_HOLD_TICKS: prdata = {16'd0, hold_reg};
            REG_FADE_TICKS: prdata = {16'd0, fade_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pv_next         = pv_reg;
        pidx_next       = pidx_reg;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        used_next       = used_reg;
        delta_next      = delta_reg;
        q_next          = q_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        best_next       = best_reg;
        granted_next    = granted_reg;
        slot_next       = slot_reg;
        evicted_next    = evicted_reg;
        opacity_next    = opacity_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        max_next        = max_reg;
        hold_next       = hold_reg;
        fade_next       = fade_reg;

        age_we          = 1'b0;
        age_wdata       = 16'd0;
        hf_we           = 1'b0;
        waddr           = pidx_reg;
        div_req.start   = 1'b0;
        div_req.num     = 32'd0;
        div_req.den     = hf_rd[31:16];

        // scan control shared by tick and spawn
        scan_end = (state_reg == S_TICK) ? SLOTS_C : used_reg;
        issue    = (idx_reg < scan_end);

        // saturating age update and end of life
        age_sum = {1'b0, age_rd} + {1'b0, delta_reg};
        age_sat = age_sum[16] ? 16'hFFFF : age_sum[15:0];
        life    = {1'b0, hf_rd[15:0]} + {1'b0, hf_rd[31:16]};

        // effective slot limit
        limit   = (MW'(max_reg) > MW'(SLOTS_C)) ? MW'(SLOTS_C) : MW'(max_reg);
        open_ok = (MW'(used_reg) < limit);
        pick    = free_idx_reg;

        // fade arithmetic
        q_inrange = ({5'd0, q_reg} < SLOTS_W);
        over      = age_rd - hf_rd[15:0];
        dcl       = (over > hf_rd[31:16]) ? hf_rd[31:16] : over;
        remain    = hf_rd[31:16] - dcl;

        // configuration writes
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAX_SLOTS:  max_next  = pwdata[6:0];
                REG_HOLD_TICKS: hold_next = pwdata[15:0];
                REG_FADE_TICKS: fade_next = pwdata[15:0];
                default:        max_next  = max_reg;
            endcase
        end

        // output register drains
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    delta_next      = s_tdata[15:0];
                    q_next          = s_tdata[21:16];
                    idx_next        = '0;
                    pv_next         = 1'b0;
                    free_found_next = 1'b0;
                    old_found_next  = 1'b0;
                    best_next       = 16'd0;
                    granted_next    = 1'b0;
                    slot_next       = 6'd0;
                    evicted_next    = 1'b0;
                    opacity_next    = 16'd0;
                    case (in_cmd)
                        CMD_TICK:  state_next = S_TICK;
                        CMD_SPAWN: state_next = S_SPN_SCAN;
                        CMD_CLEAR:
                        begin
                            active_next = '0;
                            cnt_next    = '0;
                            state_next  = S_DONE;
                        end
                        CMD_QUERY: state_next = S_QRD;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end

            S_TICK, S_SPN_SCAN:
            begin
                // issue next read
                if (issue)
                begin
                    idx_next  = idx_reg + CW'(1);
                    pv_next   = 1'b1;
                    pidx_next = idx_reg[IW-1:0];
                end
                else
                begin
                    pv_next = 1'b0;
                end

                // handle the slot whose data just came back
                if (pv_reg)
                begin
                    if (state_reg == S_TICK)
                    begin
                        if (active_reg[pidx_reg])
                        begin
                            age_we    = 1'b1;
                            age_wdata = age_sat;
                            if ({1'b0, age_sat} >= life)
                            begin
                                active_next[pidx_reg] = 1'b0;
                                cnt_next              = cnt_reg - CW'(1);
                            end
                        end
                    end
                    else if (!active_reg[pidx_reg])
                    begin
                        if (!free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = pidx_reg;
                        end
                    end
                    else if (!old_found_reg || (age_rd > best_reg))
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = pidx_reg;
                        best_next      = age_rd;
                    end
                end

                if (!issue && !pv_reg)
                begin
                    state_next = (state_reg == S_TICK) ? S_DONE : S_SPN_WR;
                end
            end

            S_SPN_WR:
            begin
                // free slot first, then a new one, then the oldest
                if (free_found_reg)
                begin
                    pick         = free_idx_reg;
                    granted_next = 1'b1;
                end
                else if (open_ok)
                begin
                    pick         = used_reg[IW-1:0];
                    used_next    = used_reg + CW'(1);
                    granted_next = 1'b1;
                end
                else if (old_found_reg)
                begin
                    pick         = old_idx_reg;
                    granted_next = 1'b1;
                    evicted_next = 1'b1;
                end

                if (granted_next)
                begin
                    waddr             = pick;
                    age_we            = 1'b1;
                    age_wdata         = 16'd0;
                    hf_we             = 1'b1;
                    active_next[pick] = 1'b1;
                    slot_next         = 6'(pick);
                    if (!evicted_next)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                state_next = S_DONE;
            end

            S_QRD:
            begin
                state_next = S_QCALC;
            end

            S_QCALC:
            begin
                state_next = S_DONE;
                if (!q_inrange || !active_reg[qidx])
                begin
                    opacity_next = 16'd0;
                end
                else if (age_rd < hf_rd[15:0])
                begin
                    opacity_next = OPACITY_FULL;
                end
                else if (hf_rd[31:16] == 16'd0)
                begin
                    opacity_next = 16'd0;
                end
                else
                begin
                    // remain * 65535 / fade
                    div_req.start = 1'b1;
                    div_req.num   = {remain, 16'd0} - {16'd0, remain};
                    state_next    = S_QDIV;
                end
            end

            S_QDIV:
            begin
                if (div_done)
                begin
                    opacity_next = div_quo;
                    state_next   = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, 7'(cnt_reg), opacity_reg, evicted_reg,
                                     slot_reg, granted_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            pv_reg         <= 1'b0;
            pidx_reg       <= '0;
            active_reg     <= '0;
            cnt_reg        <= '0;
            used_reg       <= '0;
            delta_reg      <= '0;
            q_reg          <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            old_found_reg  <= 1'b0;
            old_idx_reg    <= '0;
            best_reg       <= '0;
            granted_reg    <= 1'b0;
            slot_reg       <= '0;
            evicted_reg    <= 1'b0;
            opacity_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            max_reg        <= MAX_SLOTS_RST;
            hold_reg       <= HOLD_TICKS_RST;
            fade_reg       <= FADE_TICKS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            pv_reg         <= pv_next;
            pidx_reg       <= pidx_next;
            active_reg     <= active_next;
            cnt_reg        <= cnt_next;
            used_reg       <= used_next;
            delta_reg      <= delta_next;
            q_reg          <= q_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            old_found_reg  <= old_found_next;
            old_idx_reg    <= old_idx_next;
            best_reg       <= best_next;
            granted_reg    <= granted_next;
            slot_reg       <= slot_next;
            evicted_reg    <= evicted_next;
            opacity_reg    <= opacity_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_tdata_reg    <= m_tdata_next;
            max_reg        <= max_next;
            hold_reg       <= hold_next;
            fade_reg       <= fade_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(active_reg) == int'(cnt_reg))
        else $error("active count out of step with slot valid bits");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= SLOTS_C)
        else $error("slots in use exceed pool size");

    a_active_in_used: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= used_reg)
        else $error("more active slots than slots in use");

    a_idle_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pv_reg)
        else $error("scan data pending while idle");

endmodule

@@ design/asp_ram.sv @@
// ----------------------------------------------------------------------------
// asp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/asp_div.sv @@
// ----------------------------------------------------------------------------
// asp_div
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// num[31:16] < den, so the quotient fits 16 bits and takes 16 steps.
// ----------------------------------------------------------------------------
module asp_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  asp_pkg::asp_div_req_t req,
    output logic                 done,
    output logic [15:0]          quo
);
    import asp_pkg::*;

    logic [15:0] rem_reg,  rem_next;
    logic [15:0] lo_reg,   lo_next;
    logic [15:0] den_reg,  den_next;
    logic [15:0] quo_reg,  quo_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic        done_reg, done_next;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    // One shift-compare-subtract step
    always_comb
    begin
        trial = {rem_reg, lo_reg[15]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});

        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            rem_next = req.num[31:16];
            lo_next  = req.num[15:0];
            den_next = req.den;
            cnt_next = 5'd16;
        end
        else if (cnt_reg != 5'd0)
        begin
            rem_next  = ge ? diff[15:0] : trial[15:0];
            lo_next   = {lo_reg[14:0], 1'b0};
            quo_next  = {quo_reg[14:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            lo_reg   <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            lo_reg   <= lo_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
